// ----- hw/rtl/clb_pkg.sv -----
package clb_pkg;

  localparam int MAX_MAP_DIM_DEF = 32;
  localparam int MAX_DEPTH_DEF   = 8;
  localparam int MAX_KERNEL_DEF  = 8;
  localparam int MAX_FILTERS_DEF = 16;

  localparam int STRIDE_MAX = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam int VAL_W      = 16;
  localparam int PROD_W     = 32;
  localparam int ACC_W      = 40;

  localparam logic KIND_DW = 1'b0;
  localparam logic KIND_DX = 1'b1;

  typedef enum logic [2:0] {
    ACT_WEIGHT   = 3'd0,
    ACT_INPUT    = 3'd1,
    ACT_OUTGRAD  = 3'd2,
    ACT_CLEAR_DW = 3'd3,
    ACT_RUN      = 3'd4,
    ACT_READ_DW  = 3'd5,
    ACT_READ_DX  = 3'd6,
    ACT_NOP      = 3'd7
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_ROWS     = 4'd0,
    CFG_IN_COLS     = 4'd1,
    CFG_IN_DEPTH    = 4'd2,
    CFG_KERNEL_ROWS = 4'd3,
    CFG_KERNEL_COLS = 4'd4,
    CFG_NUM_FILTERS = 4'd5,
    CFG_STEP_SIZE   = 4'd6,
    CFG_RELU_ENABLE = 4'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLR_ALL,
    ST_IDLE,
    ST_CLR_W,
    ST_RELU,
    ST_CLR_X,
    ST_MAC_RD,
    ST_MAC_MUL,
    ST_MAC_ACC
  } state_t;

  typedef struct packed {
    action_t                   action;
    logic [4:0]                row;
    logic [4:0]                col;
    logic [3:0]                channel;
    logic [3:0]                filter_index;
    logic signed [VAL_W-1:0]   value;
    logic signed [VAL_W-1:0]   activation;
  } in_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] grad_value;
    logic                    grad_kind;
  } out_item_t;

  function automatic int addr_bits(int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  function automatic int clampi(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_add(logic signed [ACC_W-1:0] a,
                                                      logic signed [PROD_W-1:0] p);
    logic signed [ACC_W:0] s;
    s = (ACC_W+1)'(a) + (ACC_W+1)'(p);
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_add = s[ACC_W-1:0];
    end
  endfunction

endpackage

// ----- hw/rtl/clb_ram.sv -----
module clb_ram
  import clb_pkg::*;
#(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = addr_bits(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/conv_layer_backprop_unit.sv -----
// Load and read-back items are taken while idle and may follow back to back;
// a read result strobes on out_valid in the cycle after its transfer.
// Clear dW holds busy while it zeroes all MAX_FILTERS*MAX_DEPTH*MAX_KERNEL^2 dW entries. A run holds busy for
// an optional ReLU pass over the MAX_FILTERS*MAX_MAP_DIM^2 output gradients, a dX clear over
// MAX_DEPTH*MAX_MAP_DIM^2 entries, then each MAC in turn (read, multiply, write back).
// After reset a pass over max(dW, dX) entries zeroes both accumulators while busy is high.
module conv_layer_backprop_unit
  import clb_pkg::*;
#(
  parameter int MAX_MAP_DIM = MAX_MAP_DIM_DEF,
  parameter int MAX_DEPTH   = MAX_DEPTH_DEF,
  parameter int MAX_KERNEL  = MAX_KERNEL_DEF,
  parameter int MAX_FILTERS = MAX_FILTERS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_data,
  output logic                  out_valid,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int W_SIZE  = MAX_FILTERS * MAX_DEPTH * MAX_KERNEL * MAX_KERNEL;
  localparam int X_SIZE  = MAX_DEPTH * MAX_MAP_DIM * MAX_MAP_DIM;
  localparam int O_SIZE  = MAX_FILTERS * MAX_MAP_DIM * MAX_MAP_DIM;
  localparam int WX_SIZE = (W_SIZE > X_SIZE) ? W_SIZE : X_SIZE;
  localparam int SW_MAX  = (WX_SIZE > O_SIZE) ? WX_SIZE : O_SIZE;
  localparam int W_AW    = addr_bits(W_SIZE);
  localparam int X_AW    = addr_bits(X_SIZE);
  localparam int O_AW    = addr_bits(O_SIZE);
  localparam int SW      = $clog2(SW_MAX + 1);
  localparam int MDW     = $clog2(MAX_MAP_DIM + 1);
  localparam int DW      = $clog2(MAX_DEPTH + 1);
  localparam int KW      = $clog2(MAX_KERNEL + 1);
  localparam int FW      = $clog2(MAX_FILTERS + 1);
  localparam int STW     = $clog2(STRIDE_MAX + 1);

  // Configuration registers.
  logic [5:0] in_rows_r, in_cols_r;
  logic [3:0] in_depth_r, kernel_rows_r, kernel_cols_r, step_size_r;
  logic [4:0] num_filters_r;
  logic       relu_enable_r;

  // Run geometry, clamped when the run is taken.
  logic [MDW-1:0] ir_r, ic_r;
  logic [KW-1:0]  krn_r, kcn_r;
  logic [DW-1:0]  dep_r;
  logic [FW-1:0]  nf_r;
  logic [STW-1:0] st_r;

  // Loop position.
  logic [FW-1:0]  f_r, f_nxt;
  logic [KW-1:0]  kr_r, kr_nxt, kc_r, kc_nxt;
  logic [DW-1:0]  d_r, d_nxt;
  logic [MDW-1:0] orow_r, orow_nxt, ocol_r, ocol_nxt, orb_r, orb_nxt, ocb_r, ocb_nxt;
  logic [SW-1:0]  cnt_r, cnt_nxt;

  state_t state_r, state_nxt;

  logic signed [PROD_W-1:0] px_r, pw_r;
  logic rd_valid_r, rd_kind_r, rd_zero_r;

  logic accept;
  int   ir_c, ic_c, kr_c, kc_c;

  logic [W_AW-1:0] in_w_addr, mac_w_addr;
  logic [X_AW-1:0] in_x_addr, mac_x_addr;
  logic [O_AW-1:0] in_o_addr, mac_o_addr;
  logic w_ok, x_ok, o_ok;

  logic col_last, row_last, d_last, kc_last, kr_last, f_last, mac_done, sweep_done;

  // Memory ports.
  logic             w_we, x_we, o_we, dw_we, dx_we;
  logic [W_AW-1:0]  dw_waddr, dw_raddr;
  logic [X_AW-1:0]  dx_waddr, dx_raddr;
  logic [O_AW-1:0]  o_waddr, o_raddr;
  logic [VAL_W:0]   o_wdata, o_rdata;
  logic [VAL_W-1:0] w_rdata, x_rdata;
  logic [ACC_W-1:0] dw_wdata, dx_wdata, dw_rdata, dx_rdata;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_rows_r     <= 6'd28;
      in_cols_r     <= 6'd28;
      in_depth_r    <= 4'd1;
      kernel_rows_r <= 4'd5;
      kernel_cols_r <= 4'd5;
      num_filters_r <= 5'd8;
      step_size_r   <= 4'd1;
      relu_enable_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IN_ROWS:     in_rows_r     <= cfg_data[5:0];
        CFG_IN_COLS:     in_cols_r     <= cfg_data[5:0];
        CFG_IN_DEPTH:    in_depth_r    <= cfg_data[3:0];
        CFG_KERNEL_ROWS: kernel_rows_r <= cfg_data[3:0];
        CFG_KERNEL_COLS: kernel_cols_r <= cfg_data[3:0];
        CFG_NUM_FILTERS: num_filters_r <= cfg_data[4:0];
        CFG_STEP_SIZE:   step_size_r   <= cfg_data[3:0];
        CFG_RELU_ENABLE: relu_enable_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ir_c = clampi(int'(in_rows_r), 1, MAX_MAP_DIM);
    ic_c = clampi(int'(in_cols_r), 1, MAX_MAP_DIM);
    kr_c = clampi(int'(kernel_rows_r), 1, MAX_KERNEL);
    kc_c = clampi(int'(kernel_cols_r), 1, MAX_KERNEL);
    if (kr_c > ir_c) begin
      kr_c = ir_c;
    end
    if (kc_c > ic_c) begin
      kc_c = ic_c;
    end
  end

  // Addresses of the item being transferred.
  assign w_ok = (int'(in_data.filter_index) < MAX_FILTERS) && (int'(in_data.channel) < MAX_DEPTH)
             && (int'(in_data.row) < MAX_KERNEL) && (int'(in_data.col) < MAX_KERNEL);
  assign x_ok = (int'(in_data.channel) < MAX_DEPTH) && (int'(in_data.row) < MAX_MAP_DIM)
             && (int'(in_data.col) < MAX_MAP_DIM);
  assign o_ok = (int'(in_data.channel) < MAX_FILTERS) && (int'(in_data.row) < MAX_MAP_DIM)
             && (int'(in_data.col) < MAX_MAP_DIM);

  assign in_w_addr = W_AW'(((int'(in_data.filter_index) * MAX_DEPTH + int'(in_data.channel))
                     * MAX_KERNEL + int'(in_data.row)) * MAX_KERNEL + int'(in_data.col));
  assign in_x_addr = X_AW'((int'(in_data.channel) * MAX_MAP_DIM + int'(in_data.row))
                     * MAX_MAP_DIM + int'(in_data.col));
  assign in_o_addr = O_AW'((int'(in_data.channel) * MAX_MAP_DIM + int'(in_data.row))
                     * MAX_MAP_DIM + int'(in_data.col));

  // Addresses of the current MAC.
  assign mac_w_addr = W_AW'(((int'(f_r) * MAX_DEPTH + int'(d_r)) * MAX_KERNEL + int'(kr_r))
                      * MAX_KERNEL + int'(kc_r));
  assign mac_x_addr = X_AW'((int'(d_r) * MAX_MAP_DIM + int'(orb_r) + int'(kr_r)) * MAX_MAP_DIM
                      + int'(ocb_r) + int'(kc_r));
  assign mac_o_addr = O_AW'((int'(f_r) * MAX_MAP_DIM + int'(orow_r)) * MAX_MAP_DIM
                      + int'(ocol_r));

  // An output position is the last one when the next window would run past the map.
  assign col_last = (int'(ocb_r) + int'(st_r) + int'(kcn_r)) > int'(ic_r);
  assign row_last = (int'(orb_r) + int'(st_r) + int'(krn_r)) > int'(ir_r);
  assign d_last   = int'(d_r)  == int'(dep_r) - 1;
  assign kc_last  = int'(kc_r) == int'(kcn_r) - 1;
  assign kr_last  = int'(kr_r) == int'(krn_r) - 1;
  assign f_last   = int'(f_r)  == int'(nf_r) - 1;
  assign mac_done = col_last && row_last && d_last && kc_last && kr_last && f_last;

  always_comb begin
    case (state_r)
      ST_CLR_ALL: sweep_done = int'(cnt_r) == WX_SIZE - 1;
      ST_CLR_W:   sweep_done = int'(cnt_r) == W_SIZE - 1;
      ST_CLR_X:   sweep_done = int'(cnt_r) == X_SIZE - 1;
      ST_RELU:    sweep_done = int'(cnt_r) == O_SIZE;
      default:    sweep_done = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR_ALL: if (sweep_done) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept && in_data.action == ACT_CLEAR_DW) begin
          state_nxt = ST_CLR_W;
        end else if (accept && in_data.action == ACT_RUN) begin
          state_nxt = relu_enable_r ? ST_RELU : ST_CLR_X;
        end
      end
      ST_CLR_W:   if (sweep_done) state_nxt = ST_IDLE;
      ST_RELU:    if (sweep_done) state_nxt = ST_CLR_X;
      ST_CLR_X:   if (sweep_done) state_nxt = ST_MAC_RD;
      ST_MAC_RD:  state_nxt = ST_MAC_MUL;
      ST_MAC_MUL: state_nxt = ST_MAC_ACC;
      ST_MAC_ACC: state_nxt = mac_done ? ST_IDLE : ST_MAC_RD;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and memory control.
  always_comb begin
    busy     = 1'b1;
    w_we     = 1'b0;
    x_we     = 1'b0;
    o_we     = 1'b0;
    dw_we    = 1'b0;
    dx_we    = 1'b0;
    o_waddr  = in_o_addr;
    o_wdata  = {in_data.activation > 0, in_data.value};
    o_raddr  = mac_o_addr;
    dw_raddr = mac_w_addr;
    dx_raddr = mac_x_addr;
    dw_waddr = mac_w_addr;
    dx_waddr = mac_x_addr;
    dw_wdata = sat_add(dw_rdata, px_r);
    dx_wdata = sat_add(dx_rdata, pw_r);
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        dw_raddr = in_w_addr;
        dx_raddr = in_x_addr;
        w_we     = start && in_data.action == ACT_WEIGHT && w_ok;
        x_we     = start && in_data.action == ACT_INPUT && x_ok;
        o_we     = start && in_data.action == ACT_OUTGRAD && o_ok;
      end
      ST_CLR_ALL, ST_CLR_W, ST_CLR_X: begin
        dw_waddr = W_AW'(cnt_r);
        dx_waddr = X_AW'(cnt_r);
        dw_wdata = '0;
        dx_wdata = '0;
        dw_we    = (state_r != ST_CLR_X) && int'(cnt_r) < W_SIZE;
        dx_we    = (state_r != ST_CLR_W) && int'(cnt_r) < X_SIZE;
      end
      ST_RELU: begin
        // Read one entry ahead and write the previous one back, masked.
        o_raddr = O_AW'(cnt_r);
        o_waddr = O_AW'(int'(cnt_r) - 1);
        o_wdata = {o_rdata[VAL_W], o_rdata[VAL_W] ? o_rdata[VAL_W-1:0] : {VAL_W{1'b0}}};
        o_we    = cnt_r != '0;
      end
      ST_MAC_ACC: begin
        dw_we = 1'b1;
        dx_we = 1'b1;
      end
      default: ;
    endcase
  end

  // Loop counters and sweep counter.
  always_comb begin
    f_nxt    = f_r;
    kr_nxt   = kr_r;
    kc_nxt   = kc_r;
    d_nxt    = d_r;
    orow_nxt = orow_r;
    ocol_nxt = ocol_r;
    orb_nxt  = orb_r;
    ocb_nxt  = ocb_r;
    cnt_nxt  = '0;
    if (state_r == ST_CLR_ALL || state_r == ST_CLR_W || state_r == ST_CLR_X
        || state_r == ST_RELU) begin
      cnt_nxt = sweep_done ? '0 : SW'(int'(cnt_r) + 1);
    end
    if (state_r == ST_IDLE) begin
      f_nxt    = '0;
      kr_nxt   = '0;
      kc_nxt   = '0;
      d_nxt    = '0;
      orow_nxt = '0;
      ocol_nxt = '0;
      orb_nxt  = '0;
      ocb_nxt  = '0;
    end else if (state_r == ST_MAC_ACC) begin
      if (!col_last) begin
        ocb_nxt  = MDW'(int'(ocb_r) + int'(st_r));
        ocol_nxt = MDW'(int'(ocol_r) + 1);
      end else begin
        ocb_nxt  = '0;
        ocol_nxt = '0;
        if (!row_last) begin
          orb_nxt  = MDW'(int'(orb_r) + int'(st_r));
          orow_nxt = MDW'(int'(orow_r) + 1);
        end else begin
          orb_nxt  = '0;
          orow_nxt = '0;
          if (!d_last) begin
            d_nxt = DW'(int'(d_r) + 1);
          end else begin
            d_nxt = '0;
            if (!kc_last) begin
              kc_nxt = KW'(int'(kc_r) + 1);
            end else begin
              kc_nxt = '0;
              if (!kr_last) begin
                kr_nxt = KW'(int'(kr_r) + 1);
              end else begin
                kr_nxt = '0;
                f_nxt  = FW'(int'(f_r) + 1);
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR_ALL;
      cnt_r      <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      rd_valid_r <= accept && (in_data.action == ACT_READ_DW || in_data.action == ACT_READ_DX);
    end
  end

  always_ff @(posedge clk) begin
    f_r    <= f_nxt;
    kr_r   <= kr_nxt;
    kc_r   <= kc_nxt;
    d_r    <= d_nxt;
    orow_r <= orow_nxt;
    ocol_r <= ocol_nxt;
    orb_r  <= orb_nxt;
    ocb_r  <= ocb_nxt;
    if (accept && in_data.action == ACT_RUN) begin
      ir_r  <= MDW'(ir_c);
      ic_r  <= MDW'(ic_c);
      krn_r <= KW'(kr_c);
      kcn_r <= KW'(kc_c);
      dep_r <= DW'(clampi(int'(in_depth_r), 1, MAX_DEPTH));
      nf_r  <= FW'(clampi(int'(num_filters_r), 1, MAX_FILTERS));
      st_r  <= STW'(clampi(int'(step_size_r), 1, STRIDE_MAX));
    end
    if (state_r == ST_MAC_MUL) begin
      px_r <= $signed(o_rdata[VAL_W-1:0]) * $signed(x_rdata);
      pw_r <= $signed(o_rdata[VAL_W-1:0]) * $signed(w_rdata);
    end
    rd_kind_r <= (in_data.action == ACT_READ_DX) ? KIND_DX : KIND_DW;
    rd_zero_r <= (in_data.action == ACT_READ_DX) ? !x_ok : !w_ok;
  end

  always_comb begin
    out_valid           = rd_valid_r;
    out_data.grad_kind  = rd_kind_r;
    out_data.grad_value = rd_zero_r ? '0 : ((rd_kind_r == KIND_DX) ? dx_rdata : dw_rdata);
  end

  clb_ram #(.WIDTH(VAL_W), .DEPTH(W_SIZE)) u_weight_ram (
    .clk(clk), .we(w_we), .waddr(in_w_addr), .wdata(in_data.value),
    .raddr(mac_w_addr), .rdata(w_rdata)
  );

  clb_ram #(.WIDTH(VAL_W), .DEPTH(X_SIZE)) u_input_ram (
    .clk(clk), .we(x_we), .waddr(in_x_addr), .wdata(in_data.value),
    .raddr(mac_x_addr), .rdata(x_rdata)
  );

  // Output gradient with its activation mask bit on top.
  clb_ram #(.WIDTH(VAL_W + 1), .DEPTH(O_SIZE)) u_outgrad_ram (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
    .raddr(o_raddr), .rdata(o_rdata)
  );

  clb_ram #(.WIDTH(ACC_W), .DEPTH(W_SIZE)) u_dw_ram (
    .clk(clk), .we(dw_we), .waddr(dw_waddr), .wdata(dw_wdata),
    .raddr(dw_raddr), .rdata(dw_rdata)
  );

  clb_ram #(.WIDTH(ACC_W), .DEPTH(X_SIZE)) u_dx_ram (
    .clk(clk), .we(dx_we), .waddr(dx_waddr), .wdata(dx_wdata),
    .raddr(dx_raddr), .rdata(dx_rdata)
  );

endmodule

// ----- tb/tb_conv_layer_backprop_unit.sv -----
module tb_conv_layer_backprop_unit;
  import clb_pkg::*;

  localparam int W_SIZE = 8192;
  localparam int X_SIZE = 8192;
  localparam int O_SIZE = 16384;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam longint ACC_HI = 64'sd549755813887;
  localparam longint ACC_LO = -64'sd549755813888;

  typedef enum logic [1:0] {K_CMD, K_CFG, K_DRAIN} step_kind_t;

  typedef struct {
    step_kind_t kind;
    in_item_t   cmd;
    cfg_reg_t   reg_idx;
    logic [7:0] reg_val;
  } step_t;

  typedef struct {
    int ir, ic, dep, krn, kcn, nf, st, orows, ocols;
    bit relu;
  } dims_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              in_data = '0;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  conv_layer_backprop_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predicted block state.
  logic signed [15:0] wt_mem[W_SIZE];
  logic signed [15:0] xin_mem[X_SIZE];
  logic signed [15:0] og_mem[O_SIZE];
  bit                 act_mem[O_SIZE];
  longint             dw_acc[W_SIZE];
  longint             dx_acc[X_SIZE];
  int                 pred_cfg[8] = '{28, 28, 1, 5, 5, 8, 1, 1};

  // Generator bookkeeping: which store entries have been written so far.
  bit w_wr[W_SIZE];
  bit x_wr[X_SIZE];
  bit o_wr[O_SIZE];
  int gen_cfg[8] = '{28, 28, 1, 5, 5, 8, 1, 1};

  step_t     pending_cmds[$];
  out_item_t grad_expect[$];

  int in_sent = 0, in_acc = 0, cfg_sent = 0, cfg_acc = 0;
  int bad_cnt = 0, idle_cyc = 0;
  int burst_left = 0, gap_left = 0, settle = 0;
  bit draining = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int lim(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int cfg_mask(int i, int v);
    case (cfg_reg_t'(i))
      CFG_IN_ROWS, CFG_IN_COLS: return v & 63;
      CFG_NUM_FILTERS:          return v & 31;
      CFG_RELU_ENABLE:          return v & 1;
      default:                  return v & 15;
    endcase
  endfunction

  function automatic dims_t dims_of(input int c[8]);
    dims_t d;
    d.ir = lim(c[0], 1, 32);
    d.ic = lim(c[1], 1, 32);
    d.dep = lim(c[2], 1, 8);
    d.krn = lim(c[3], 1, 8);
    d.kcn = lim(c[4], 1, 8);
    d.nf = lim(c[5], 1, 16);
    d.st = lim(c[6], 1, 8);
    d.relu = c[7][0];
    if (d.krn > d.ir) d.krn = d.ir;
    if (d.kcn > d.ic) d.kcn = d.ic;
    d.orows = (d.ir - d.krn) / d.st + 1;
    d.ocols = (d.ic - d.kcn) / d.st + 1;
    return d;
  endfunction

  function automatic int widx(int f, int d, int r, int c);
    return ((f * 8 + d) * 8 + r) * 8 + c;
  endfunction

  function automatic int xidx(int d, int r, int c);
    return (d * 32 + r) * 32 + c;
  endfunction

  function automatic int oidx(int f, int r, int c);
    return (f * 32 + r) * 32 + c;
  endfunction

  function automatic longint sat40(longint s);
    return (s > ACC_HI) ? ACC_HI : ((s < ACC_LO) ? ACC_LO : s);
  endfunction

  function automatic void backprop_sample();
    dims_t d;
    int r, c, wi, xi;
    longint g;
    d = dims_of(pred_cfg);
    if (d.relu) begin
      for (int i = 0; i < O_SIZE; i++) if (!act_mem[i]) og_mem[i] = '0;
    end
    for (int i = 0; i < X_SIZE; i++) dx_acc[i] = 0;
    for (int f = 0; f < d.nf; f++)
      for (int kr = 0; kr < d.krn; kr++)
        for (int kc = 0; kc < d.kcn; kc++)
          for (int dd = 0; dd < d.dep; dd++)
            for (int orow = 0; orow < d.orows; orow++) begin
              r = orow * d.st + kr;
              if (r < d.ir) begin
                for (int ocol = 0; ocol < d.ocols; ocol++) begin
                  c = ocol * d.st + kc;
                  if (c < d.ic) begin
                    g = longint'(og_mem[oidx(f, orow, ocol)]);
                    wi = widx(f, dd, kr, kc);
                    xi = xidx(dd, r, c);
                    dw_acc[wi] = sat40(dw_acc[wi] + g * longint'(xin_mem[xi]));
                    dx_acc[xi] = sat40(dx_acc[xi] + g * longint'(wt_mem[wi]));
                  end
                end
              end
            end
  endfunction

  function automatic void predict_cmd(input in_item_t it);
    out_item_t e;
    longint g;
    g = 0;
    case (it.action)
      ACT_WEIGHT:
        if (it.channel < 8 && it.row < 8 && it.col < 8)
          wt_mem[widx(it.filter_index, it.channel, it.row, it.col)] = it.value;
      ACT_INPUT:
        if (it.channel < 8) xin_mem[xidx(it.channel, it.row, it.col)] = it.value;
      ACT_OUTGRAD: begin
        og_mem[oidx(it.channel, it.row, it.col)] = it.value;
        act_mem[oidx(it.channel, it.row, it.col)] = ($signed(it.activation) > 0);
      end
      ACT_CLEAR_DW:
        for (int i = 0; i < W_SIZE; i++) dw_acc[i] = 0;
      ACT_RUN:
        backprop_sample();
      ACT_READ_DW: begin
        if (it.channel < 8 && it.row < 8 && it.col < 8)
          g = dw_acc[widx(it.filter_index, it.channel, it.row, it.col)];
        e.grad_value = g[ACC_W-1:0];
        e.grad_kind = KIND_DW;
        grad_expect.push_back(e);
      end
      ACT_READ_DX: begin
        if (it.channel < 8) g = dx_acc[xidx(it.channel, it.row, it.col)];
        e.grad_value = g[ACC_W-1:0];
        e.grad_kind = KIND_DX;
        grad_expect.push_back(e);
      end
      default: ;
    endcase
  endfunction

  function automatic void note_bad(input string msg);
    bad_cnt++;
    if (bad_cnt <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  task automatic push_cmd(input action_t a, input int r, c, ch, fi, v, act);
    step_t s;
    s.kind = K_CMD;
    s.reg_idx = CFG_IN_ROWS;
    s.reg_val = '0;
    s.cmd.action = a;
    s.cmd.row = 5'(r);
    s.cmd.col = 5'(c);
    s.cmd.channel = 4'(ch);
    s.cmd.filter_index = 4'(fi);
    s.cmd.value = 16'(v);
    s.cmd.activation = 16'(act);
    case (a)
      ACT_WEIGHT:  if (ch < 8 && r < 8 && c < 8) w_wr[widx(fi, ch, r, c)] = 1;
      ACT_INPUT:   if (ch < 8) x_wr[xidx(ch, r, c)] = 1;
      ACT_OUTGRAD: o_wr[oidx(ch, r, c)] = 1;
      default: ;
    endcase
    pending_cmds.push_back(s);
  endtask

  task automatic set_phase(input int v[8]);
    step_t s;
    s.kind = K_DRAIN;
    s.cmd = '0;
    s.reg_idx = CFG_IN_ROWS;
    s.reg_val = '0;
    pending_cmds.push_back(s);
    for (int i = 0; i < 8; i++) begin
      s.kind = K_CFG;
      s.reg_idx = cfg_reg_t'(i);
      s.reg_val = 8'(v[i]);
      gen_cfg[i] = cfg_mask(i, v[i]);
      pending_cmds.push_back(s);
    end
  endtask

  // Every store entry that a run will read gets written first.
  task automatic run_sample(input bit extreme);
    dims_t d;
    int v, act;
    d = dims_of(gen_cfg);
    for (int f = 0; f < d.nf; f++)
      for (int dd = 0; dd < d.dep; dd++)
        for (int r = 0; r < d.krn; r++)
          for (int c = 0; c < d.kcn; c++)
            if (!w_wr[widx(f, dd, r, c)]) begin
              v = extreme ? -32768 : $urandom_range(0, 65535);
              push_cmd(ACT_WEIGHT, r, c, dd, f, v, $urandom_range(0, 65535));
            end
    for (int dd = 0; dd < d.dep; dd++)
      for (int r = 0; r < d.ir; r++)
        for (int c = 0; c < d.ic; c++)
          if (!x_wr[xidx(dd, r, c)]) begin
            v = extreme ? -32768 : $urandom_range(0, 65535);
            push_cmd(ACT_INPUT, r, c, dd, $urandom_range(0, 15), v, $urandom_range(0, 65535));
          end
    for (int f = 0; f < d.nf; f++)
      for (int r = 0; r < d.orows; r++)
        for (int c = 0; c < d.ocols; c++)
          if (!o_wr[oidx(f, r, c)]) begin
            v = extreme ? -32768 : $urandom_range(0, 65535);
            act = extreme ? 1 : $urandom_range(0, 65535);
            push_cmd(ACT_OUTGRAD, r, c, f, $urandom_range(0, 15), v, act);
          end
    push_cmd(ACT_RUN, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic random_phase(input int ph, input int v[8]);
    dims_t d;
    int sel;
    action_t noise_ops[6];
    noise_ops = '{ACT_WEIGHT, ACT_INPUT, ACT_OUTGRAD, ACT_READ_DW, ACT_READ_DX, ACT_NOP};
    set_phase(v);
    d = dims_of(gen_cfg);
    for (int k = 0; k < 45; k++) begin
      if (k == 15 || k == 32) run_sample(0);
      if (k == 24 && ph[0]) push_cmd(ACT_CLEAR_DW, 0, 0, 0, 0, 0, 0);
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        push_cmd(noise_ops[$urandom_range(0, 5)], $urandom_range(0, 31),
                 $urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 15),
                 $urandom_range(0, 65535), $urandom_range(0, 65535));
      end else if (sel < 30) begin
        push_cmd(ACT_WEIGHT, $urandom_range(0, d.krn - 1), $urandom_range(0, d.kcn - 1),
                 $urandom_range(0, d.dep - 1), $urandom_range(0, d.nf - 1),
                 $urandom_range(0, 65535), $urandom_range(0, 65535));
      end else if (sel < 46) begin
        push_cmd(ACT_INPUT, $urandom_range(0, d.ir - 1), $urandom_range(0, d.ic - 1),
                 $urandom_range(0, d.dep - 1), $urandom_range(0, 15),
                 $urandom_range(0, 65535), $urandom_range(0, 65535));
      end else if (sel < 62) begin
        push_cmd(ACT_OUTGRAD, $urandom_range(0, d.orows - 1), $urandom_range(0, d.ocols - 1),
                 $urandom_range(0, d.nf - 1), $urandom_range(0, 15),
                 $urandom_range(0, 65535), $urandom_range(0, 65535));
      end else if (sel < 80) begin
        push_cmd(ACT_READ_DW, $urandom_range(0, d.krn - 1), $urandom_range(0, d.kcn - 1),
                 $urandom_range(0, d.dep - 1), $urandom_range(0, d.nf - 1), 0, 0);
      end else begin
        push_cmd(ACT_READ_DX, $urandom_range(0, d.ir - 1), $urandom_range(0, d.ic - 1),
                 $urandom_range(0, d.dep - 1), $urandom_range(0, 15), 0, 0);
      end
    end
  endtask

  // Driver: a new command, register write or drain starts only after the
  // previous transfer has been seen at a rising edge.
  always @(negedge clk) begin
    step_t s;
    logic nstart, ncfg;
    nstart = start;
    ncfg = cfg_valid;
    if (!rst_n) begin
      nstart = 1'b0;
      ncfg = 1'b0;
    end else if (start && in_acc != in_sent) begin
    end else if (cfg_valid && cfg_acc != cfg_sent) begin
    end else if (draining) begin
      nstart = 1'b0;
      ncfg = 1'b0;
      if (grad_expect.size() == 0) settle++;
      if (settle >= 4 && !busy) draining = 0;
    end else begin
      nstart = 1'b0;
      ncfg = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_cmds.size() > 0) begin
        s = pending_cmds.pop_front();
        case (s.kind)
          K_CMD: begin
            nstart = 1'b1;
            in_data <= s.cmd;
            in_sent++;
            if (burst_left == 0) begin
              burst_left = $urandom_range(1, 40);
              gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
              burst_left--;
            end
          end
          K_CFG: begin
            ncfg = 1'b1;
            cfg_index <= s.reg_idx;
            cfg_data <= s.reg_val;
            cfg_sent++;
          end
          default: begin
            draining = 1;
            settle = 0;
          end
        endcase
      end
    end
    start <= nstart;
    cfg_valid <= ncfg;
  end

  always @(posedge clk) begin
    out_item_t e;
    bit moved;
    if (rst_n) begin
      moved = 0;
      if (out_valid) begin
        moved = 1;
        if (grad_expect.size() == 0) begin
          note_bad($sformatf("unexpected result value=%0d kind=%0b",
                             out_data.grad_value, out_data.grad_kind));
        end else begin
          e = grad_expect.pop_front();
          if (out_data.grad_value !== e.grad_value || out_data.grad_kind !== e.grad_kind)
            note_bad($sformatf("mismatch: expected value=%0d kind=%0b, got value=%0d kind=%0b",
                               e.grad_value, e.grad_kind,
                               out_data.grad_value, out_data.grad_kind));
        end
      end
      if (start && !busy) begin
        moved = 1;
        predict_cmd(in_data);
        in_acc <= in_acc + 1;
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1;
        pred_cfg[cfg_index] = cfg_mask(int'(cfg_index), int'(cfg_data));
        cfg_acc <= cfg_acc + 1;
      end
      idle_cyc <= moved ? 0 : idle_cyc + 1;
      if (idle_cyc >= WATCHDOG_LIMIT) begin
        $display("conv_layer_backprop_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    // Short directed opening under the reset configuration.
    push_cmd(ACT_NOP, 31, 31, 15, 15, 65535, 65535);
    push_cmd(ACT_READ_DW, 0, 0, 0, 0, 0, 0);
    push_cmd(ACT_READ_DX, 0, 0, 0, 0, 0, 0);
    push_cmd(ACT_READ_DW, 31, 31, 15, 15, 0, 0);
    push_cmd(ACT_READ_DX, 31, 31, 15, 0, 0, 0);
    push_cmd(ACT_WEIGHT, 9, 0, 0, 0, 1234, 0);
    push_cmd(ACT_WEIGHT, 7, 7, 7, 15, -32768, 0);
    push_cmd(ACT_INPUT, 5, 5, 12, 0, 32767, 0);
    push_cmd(ACT_INPUT, 31, 31, 7, 0, 32767, 0);
    push_cmd(ACT_OUTGRAD, 31, 31, 15, 0, 32767, -32768);
    push_cmd(ACT_CLEAR_DW, 0, 0, 0, 0, 0, 0);
    push_cmd(ACT_READ_DW, 7, 7, 7, 15, 0, 0);
    push_cmd(ACT_READ_DX, 31, 31, 7, 0, 0, 0);

    // An 8x8 map with a 1x1 kernel gives 64 maximal products per run. dW keeps
    // growing across runs until it saturates, and later runs must hold it there.
    set_phase('{8, 8, 1, 1, 1, 1, 1, 1});
    run_sample(1);
    push_cmd(ACT_READ_DW, 0, 0, 0, 0, 0, 0);
    push_cmd(ACT_READ_DX, 0, 0, 0, 0, 0, 0);
    push_cmd(ACT_READ_DX, 7, 7, 0, 0, 0, 0);
    for (int n = 0; n < 9; n++) begin
      push_cmd(ACT_RUN, 0, 0, 0, 0, 0, 0);
      push_cmd(ACT_READ_DW, 0, 0, 0, 0, 0, 0);
    end
    push_cmd(ACT_READ_DX, 5, 3, 0, 0, 0, 0);

    random_phase(0, '{4, 5, 2, 2, 3, 3, 1, 1});
    random_phase(1, '{10, 10, 1, 6, 6, 1, 4, 0});
    random_phase(2, '{0, 63, 0, 15, 0, 0, 0, 1});
    random_phase(3, '{3, 3, 9, 8, 1, 1, 2, 0});

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait (pending_cmds.size() == 0 && !start && !cfg_valid && !draining);
    wait (grad_expect.size() == 0);
    repeat (20) @(posedge clk);
    if (bad_cnt == 0 && grad_expect.size() == 0) begin
      $display("conv_layer_backprop_unit test passed");
    end else begin
      $display("conv_layer_backprop_unit test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/clb_pkg.sv
hw/rtl/clb_ram.sv
hw/rtl/conv_layer_backprop_unit.sv
tb/tb_conv_layer_backprop_unit.sv
